@@ rtl/wpd_pkg.sv @@
// ----------------------------------------------------------------------------
// wpd_pkg
// Shared types and constants of the worker pool dispatcher.
// ----------------------------------------------------------------------------
package wpd_pkg;

    // default sizes of the pool and of the process table
    localparam int WORKERS_DEF = 8;
    localparam int PROCS_DEF   = 256;

    // width of one word of the pending bitmap, scanned one word per cycle
    localparam int SCAN_W  = 32;
    localparam int SCAN_IW = $clog2(SCAN_W);

    // results of one allow item at most, and free workers a plain start needs
    localparam int MAX_RESULTS = 8;
    localparam int SPARE_NEED  = 2;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    // item field widths
    localparam int OP_W     = 2;
    localparam int PROC_W   = 8;
    localparam int WIDX_W   = 3;
    localparam int STATUS_W = 3;
    localparam int BUSY_W   = 4;
    localparam int PEND_W   = 9;

    // stream widths
    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = OP_W;
    localparam int M_TDATA_W = 32;

    typedef enum logic [OP_W-1:0] {
        OP_START  = 2'd0,
        OP_FINISH = 2'd1,
        OP_ALLOW  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK          = 3'd0,
        STS_PENDING     = 3'd1,
        STS_PEND_ACTIVE = 3'd2,
        STS_DUP_NORMAL  = 3'd3,
        STS_DUP_PM      = 3'd4,
        STS_ADMIN       = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_READY,
        S_START,
        S_FINISH,
        S_ALLOW,
        S_NOP,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_TAKE
    } state_t;

    // one decoded input item
    typedef struct packed {
        op_t               op;
        logic [PROC_W-1:0] proc_index;
        logic              pm_job;
        logic              spare_ok;
        logic [WIDX_W-1:0] worker_index;
        logic              allow_work;
    } item_t;

    // one result item
    typedef struct packed {
        logic              assigned;
        logic [WIDX_W-1:0] assigned_worker;
        logic [PROC_W-1:0] assigned_proc;
        status_t           status;
        logic [BUSY_W-1:0] busy_count;
        logic [PEND_W-1:0] pending_count;
        logic              last_result;
    } result_t;

endpackage

@@ rtl/wpd_ffs.sv @@
// ----------------------------------------------------------------------------
// wpd_ffs
// Find-first-set unit: index of the lowest set bit of a word.
// ----------------------------------------------------------------------------
module wpd_ffs
    import wpd_pkg::*;
#(
    parameter int W = SCAN_W
) (
    input  logic [W-1:0]         vec,
    output logic                 found,
    output logic [$clog2(W)-1:0] idx
);

    // priority encoder, lowest bit wins
    always_comb begin
        found = 1'b0;
        idx   = '0;
        for (int i = W - 1; i >= 0; i--) begin
            if (vec[i]) begin
                found = 1'b1;
                idx   = ($clog2(W))'(i);
            end
        end
    end

endmodule

@@ rtl/wpd_seq.sv @@
// ----------------------------------------------------------------------------
// wpd_seq
// Dispatch sequencer: process table, pending bitmap, worker table and the
// step control around the shared find-first unit.
// ----------------------------------------------------------------------------
module wpd_seq
    import wpd_pkg::*;
#(
    parameter int WORKERS = WORKERS_DEF,
    parameter int PROCS   = PROCS_DEF
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    item_valid,
    input  item_t   item_in,
    output logic    item_ready,
    input  logic    res_ready,
    output logic    res_push,
    output result_t res_out
);

    localparam int WW   = $clog2(WORKERS);
    localparam int AW   = $clog2(WORKERS + 1);
    localparam int PW   = $clog2(PROCS);
    localparam int NW   = $clog2(PROCS + 1);
    localparam int ROWS = (PROCS + SCAN_W - 1) / SCAN_W;
    localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int PIW  = RW + SCAN_IW;
    localparam int DW   = AW + 2;
    localparam int PCW  = (NW > PROC_W) ? NW : PROC_W;
    localparam int WCW  = (AW > WIDX_W) ? AW : WIDX_W;

    // process word: has normal, has PM, active worker + 1
    localparam int HN_BIT = AW + 1;
    localparam int HP_BIT = AW;

    state_t state_reg, state_next;
    item_t  item_reg, item_next;

    logic [WORKERS-1:0] busy_vec_reg, busy_vec_next;
    logic [PIW-1:0]     owner_reg [WORKERS];
    logic [PIW-1:0]     owner_next [WORKERS];
    logic [AW-1:0]      busy_total_reg, busy_total_next;
    logic [NW-1:0]      pending_total_reg, pending_total_next;
    logic               block_reg, block_next;
    logic [RW-1:0]      row_reg, row_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [PIW-1:0]     q_reg, q_next;
    logic [PW-1:0]      clr_reg, clr_next;

    // memories and their ports
    logic [DW-1:0]     proc_mem [PROCS];
    logic [SCAN_W-1:0] pend_mem [ROWS];
    logic [DW-1:0]     proc_rd_reg;
    logic [SCAN_W-1:0] pend_rd_reg;
    logic              proc_we, pend_we;
    logic [PW-1:0]     proc_waddr, proc_raddr;
    logic [RW-1:0]     pend_waddr, pend_raddr;
    logic [DW-1:0]     proc_wdata;
    logic [SCAN_W-1:0] pend_wdata;

    // shared find-first unit
    logic [SCAN_W-1:0]  ffs_vec;
    logic               ffs_found;
    logic [SCAN_IW-1:0] ffs_idx;

    // decoded helpers
    logic [PIW-1:0]    in_p, item_p, q_found;
    logic [WW-1:0]     item_w, take_w;
    logic [SCAN_W-1:0] free_vec;
    logic              p_ok, w_ok, fin_take, al_take, take_last, row_last, clr_row_ok;
    logic              pend_bit, act, has_n, has_p, fits;
    logic [AW:0]       need_w;

    assign in_p     = PIW'(item_in.proc_index);
    assign item_p   = PIW'(item_reg.proc_index);
    assign item_w   = WW'(item_reg.worker_index);
    assign q_found  = {row_reg, ffs_idx};
    assign free_vec = SCAN_W'(~busy_vec_reg);
    assign row_last = (row_reg == RW'(ROWS - 1));
    assign clr_row_ok = ({1'b0, clr_reg} < (PW + 1)'(ROWS));

    assign ffs_vec = (state_reg == S_SCAN_CHK) ? pend_rd_reg : free_vec;

    wpd_ffs #(
        .W (SCAN_W)
    ) u_ffs (
        .vec   (ffs_vec),
        .found (ffs_found),
        .idx   (ffs_idx)
    );

    // conditions shared by next-state and datapath
    always_comb begin
        p_ok     = PCW'(item_reg.proc_index) < PCW'(PROCS);
        pend_bit = pend_rd_reg[item_p[SCAN_IW-1:0]];
        act      = (proc_rd_reg[AW-1:0] != '0);
        has_n    = proc_rd_reg[HN_BIT];
        has_p    = proc_rd_reg[HP_BIT];
        need_w   = item_reg.spare_ok ? (AW + 1)'(1) : (AW + 1)'(SPARE_NEED);
        fits     = ((AW + 1)'(busy_total_reg) + need_w) <= (AW + 1)'(WORKERS);
        w_ok     = (WCW'(item_reg.worker_index) < WCW'(WORKERS)) && busy_vec_reg[item_w];
        fin_take = (pending_total_reg != '0) && (busy_total_reg < AW'(WORKERS)) && !block_reg;
        al_take  = (pending_total_reg != '0) && item_reg.allow_work &&
                   (((AW + 1)'(busy_total_reg) + (AW + 1)'(1)) < (AW + 1)'(WORKERS));
        take_w   = (item_reg.op == OP_FINISH) ? item_w : ffs_idx[WW-1:0];
        take_last = (item_reg.op == OP_FINISH) ||
                    (cnt_reg == CNT_W'(MAX_RESULTS - 1)) ||
                    !((pending_total_reg != '0) && !block_reg &&
                      (((AW + 1)'(busy_total_reg) + (AW + 1)'(2)) < (AW + 1)'(WORKERS)));
    end

    // read addresses
    always_comb begin
        case (state_reg)
            S_READY:    proc_raddr = in_p[PW-1:0];
            S_SCAN_CHK: proc_raddr = q_found[PW-1:0];
            S_TAKE:     proc_raddr = q_reg[PW-1:0];
            default:    proc_raddr = item_p[PW-1:0];
        endcase
        case (state_reg)
            S_READY:    pend_raddr = in_p[PIW-1:SCAN_IW];
            S_START:    pend_raddr = item_p[PIW-1:SCAN_IW];
            S_SCAN_CHK: pend_raddr = (!ffs_found && !row_last) ? row_reg + RW'(1) : row_reg;
            default:    pend_raddr = row_reg;
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: begin
                if (clr_reg == PW'(PROCS - 1)) state_next = S_READY;
            end
            S_READY: begin
                if (item_valid) begin
                    case (item_in.op)
                        OP_START:  state_next = S_START;
                        OP_FINISH: state_next = S_FINISH;
                        OP_ALLOW:  state_next = S_ALLOW;
                        default:   state_next = S_NOP;
                    endcase
                end
            end
            S_START, S_NOP: begin
                if (res_ready) state_next = S_READY;
            end
            S_FINISH: begin
                if (w_ok && fin_take) state_next = S_SCAN_RD;
                else if (res_ready)   state_next = S_READY;
            end
            S_ALLOW: begin
                if (al_take)        state_next = S_SCAN_RD;
                else if (res_ready) state_next = S_READY;
            end
            S_SCAN_RD: state_next = S_SCAN_CHK;
            S_SCAN_CHK: begin
                if (ffs_found)                  state_next = S_TAKE;
                else if (row_last && res_ready) state_next = S_READY;
            end
            S_TAKE: begin
                if (res_ready) state_next = take_last ? S_READY : S_SCAN_RD;
            end
            default: state_next = S_CLEAR;
        endcase
    end

    // datapath, table writes and results
    always_comb begin
        item_next          = item_reg;
        busy_vec_next      = busy_vec_reg;
        owner_next         = owner_reg;
        busy_total_next    = busy_total_reg;
        pending_total_next = pending_total_reg;
        block_next         = block_reg;
        row_next           = row_reg;
        cnt_next           = cnt_reg;
        q_next             = q_reg;
        clr_next           = clr_reg;
        item_ready         = 1'b0;
        proc_we            = 1'b0;
        proc_waddr         = item_p[PW-1:0];
        proc_wdata         = proc_rd_reg;
        pend_we            = 1'b0;
        pend_waddr         = row_reg;
        pend_wdata         = pend_rd_reg;
        res_push           = 1'b0;
        res_out            = '0;
        res_out.status     = STS_OK;
        res_out.last_result = 1'b1;

        case (state_reg)
            // zero both tables, one entry per cycle
            S_CLEAR: begin
                proc_we    = 1'b1;
                proc_waddr = clr_reg;
                proc_wdata = '0;
                pend_we    = clr_row_ok;
                pend_waddr = RW'(clr_reg);
                pend_wdata = '0;
                clr_next   = clr_reg + PW'(1);
            end
            S_READY: begin
                item_ready = 1'b1;
                if (item_valid) item_next = item_in;
            end
            // start request, table entry already read
            S_START: begin
                if (res_ready) begin
                    res_push = 1'b1;
                    if (!p_ok) begin
                        res_out.status = STS_ADMIN;
                    end else if (pend_bit && act) begin
                        res_out.status = STS_PEND_ACTIVE;
                    end else if (pend_bit || act) begin
                        if (!item_reg.pm_job && has_n) begin
                            res_out.status = STS_DUP_NORMAL;
                        end else if (item_reg.pm_job && has_p) begin
                            res_out.status = STS_DUP_PM;
                        end else begin
                            // merge into existing work
                            proc_we = 1'b1;
                            if (item_reg.pm_job) proc_wdata[HP_BIT] = 1'b1;
                            else                 proc_wdata[HN_BIT] = 1'b1;
                            res_out.status = pend_bit ? STS_PENDING : STS_OK;
                        end
                    end else if (has_n || has_p) begin
                        res_out.status = STS_ADMIN;
                    end else begin
                        proc_we    = 1'b1;
                        proc_wdata = {!item_reg.pm_job, item_reg.pm_job, AW'(0)};
                        if (ffs_found && fits && (!block_reg || item_reg.spare_ok)) begin
                            // bind to lowest free worker
                            proc_wdata[AW-1:0] = AW'(ffs_idx) + AW'(1);
                            busy_vec_next[ffs_idx[WW-1:0]] = 1'b1;
                            owner_next[ffs_idx[WW-1:0]]    = item_p;
                            busy_total_next         = busy_total_reg + AW'(1);
                            res_out.assigned        = 1'b1;
                            res_out.assigned_worker = WIDX_W'(ffs_idx);
                            res_out.assigned_proc   = item_reg.proc_index;
                        end else begin
                            // queue as pending
                            pend_we    = 1'b1;
                            pend_waddr = item_p[PIW-1:SCAN_IW];
                            pend_wdata = pend_rd_reg | (SCAN_W'(1) << item_p[SCAN_IW-1:0]);
                            pending_total_next = pending_total_reg + NW'(1);
                            res_out.status     = STS_PENDING;
                        end
                    end
                end
            end
            // worker done: free it, then maybe take pending work
            S_FINISH: begin
                if (!w_ok) begin
                    res_push       = res_ready;
                    res_out.status = STS_ADMIN;
                end else if (fin_take || res_ready) begin
                    proc_we    = 1'b1;
                    proc_waddr = owner_reg[item_w][PW-1:0];
                    proc_wdata = '0;
                    busy_vec_next[item_w] = 1'b0;
                    busy_total_next       = busy_total_reg - AW'(1);
                    row_next              = '0;
                    res_push              = !fin_take;
                end
            end
            // set allow flag, drain if possible
            S_ALLOW: begin
                block_next = !item_reg.allow_work;
                row_next   = '0;
                cnt_next   = '0;
                if (!al_take) res_push = res_ready;
            end
            S_NOP: begin
                res_push = res_ready;
            end
            S_SCAN_RD: begin
            end
            // check one bitmap word for the lowest pending process
            S_SCAN_CHK: begin
                if (ffs_found) begin
                    pend_we    = 1'b1;
                    pend_waddr = row_reg;
                    pend_wdata = pend_rd_reg & ~(SCAN_W'(1) << ffs_idx);
                    pending_total_next = pending_total_reg - NW'(1);
                    q_next = q_found;
                end else if (row_last) begin
                    res_push       = res_ready;
                    res_out.status = STS_ADMIN;
                end else begin
                    row_next = row_reg + RW'(1);
                end
            end
            // bind the found process to its worker
            S_TAKE: begin
                if (res_ready) begin
                    proc_we    = 1'b1;
                    proc_waddr = q_reg[PW-1:0];
                    proc_wdata = {proc_rd_reg[HN_BIT], proc_rd_reg[HP_BIT],
                                  AW'(take_w) + AW'(1)};
                    busy_vec_next[take_w] = 1'b1;
                    owner_next[take_w]    = q_reg;
                    busy_total_next       = busy_total_reg + AW'(1);
                    cnt_next              = cnt_reg + CNT_W'(1);
                    res_push                = 1'b1;
                    res_out.assigned        = 1'b1;
                    res_out.assigned_worker = WIDX_W'(take_w);
                    res_out.assigned_proc   = PROC_W'(q_reg);
                    res_out.last_result     = take_last;
                end
            end
            default: begin
            end
        endcase

        res_out.busy_count    = BUSY_W'(busy_total_next);
        res_out.pending_count = PEND_W'(pending_total_next);
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= S_CLEAR;
            busy_vec_reg      <= '0;
            busy_total_reg    <= '0;
            pending_total_reg <= '0;
            block_reg         <= 1'b0;
            clr_reg           <= '0;
        end else begin
            state_reg         <= state_next;
            busy_vec_reg      <= busy_vec_next;
            busy_total_reg    <= busy_total_next;
            pending_total_reg <= pending_total_next;
            block_reg         <= block_next;
            clr_reg           <= clr_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        item_reg  <= item_next;
        owner_reg <= owner_next;
        row_reg   <= row_next;
        cnt_reg   <= cnt_next;
        q_reg     <= q_next;
    end

    // table memories, registered reads
    always_ff @(posedge aclk) begin
        if (proc_we) proc_mem[proc_waddr] <= proc_wdata;
        if (pend_we) pend_mem[pend_waddr] <= pend_wdata;
        proc_rd_reg <= proc_mem[proc_raddr];
        pend_rd_reg <= pend_mem[pend_raddr];
    end

    // busy counter tracks the busy flags
    a_busy_count: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(busy_vec_reg) == 32'(busy_total_reg))
        else $error("busy count out of step with busy flags");

    // never push into a full output stage
    a_push_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        res_push |-> res_ready)
        else $error("result pushed while output stage full");

    // final result of an item returns to accepting
    a_last_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_push && res_out.last_result) |=> (state_reg == S_READY))
        else $error("sequencer not ready after final result");

    // an assignment from a pending scan always names a free worker in the pool
    a_take_worker: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_TAKE && res_push) |-> (32'(take_w) < WORKERS && !busy_vec_reg[take_w]))
        else $error("pending work bound to a busy or missing worker");

endmodule

@@ rtl/worker_pool_dispatcher_unit.sv @@
// ----------------------------------------------------------------------------
// worker_pool_dispatcher_unit
// Hands per-process jobs to a pool of workers with one spare in reserve.
//
// After reset the block zeroes its process table, one entry per cycle, and
// s_tready stays low meanwhile. Items are then taken one at a time. A start
// item reads its table entry and then gives its result. A finish item frees
// its worker; when it takes pending work, it then reads the 32-bit words of
// the pending bitmap up to and including the word that holds the lowest
// pending process and binds that process to the freed worker. An allow item
// sets its flag and may then make assignments one after another, the bitmap
// scan resuming at the word where the previous one stopped. The pending
// bitmap is scanned through one shared find-first unit.
// A result waits in the output register while the next item is accepted.
// ----------------------------------------------------------------------------
module worker_pool_dispatcher_unit
    import wpd_pkg::*;
#(
    parameter int WORKERS = WORKERS_DEF,
    parameter int PROCS   = PROCS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // input items
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // proc_index[7:0], pm_job[8], spare_ok[9], worker_index[12:10],
    // allow_work[13], zero[15:14]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // op[1:0]
    input  logic [S_TUSER_W-1:0] s_tuser,
    // result items
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // assigned[0], assigned_worker[3:1], assigned_proc[11:4], status[14:12],
    // busy_count[18:15], pending_count[27:19], zero[31:28]
    output logic [M_TDATA_W-1:0] m_tdata,
    // last_result
    output logic                 m_tlast
);

    localparam int M_USED_W = 1 + WIDX_W + PROC_W + STATUS_W + BUSY_W + PEND_W;

    item_t   item_in;
    result_t res;
    logic    item_ready, res_ready, res_push;

    logic                 m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;
    logic                 m_last_reg;

    // unpack input item
    always_comb begin
        item_in.op           = op_t'(s_tuser);
        item_in.proc_index   = s_tdata[7:0];
        item_in.pm_job       = s_tdata[8];
        item_in.spare_ok     = s_tdata[9];
        item_in.worker_index = s_tdata[12:10];
        item_in.allow_work   = s_tdata[13];
    end

    wpd_seq #(
        .WORKERS (WORKERS),
        .PROCS   (PROCS)
    ) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (s_tvalid),
        .item_in    (item_in),
        .item_ready (item_ready),
        .res_ready  (res_ready),
        .res_push   (res_push),
        .res_out    (res)
    );

    assign s_tready  = item_ready;
    assign res_ready = !m_valid_reg || m_tready;

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_push;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_push) begin
            m_data_reg <= {{(M_TDATA_W - M_USED_W){1'b0}}, res.pending_count,
                           res.busy_count, res.status, res.assigned_proc,
                           res.assigned_worker, res.assigned};
            m_last_reg <= res.last_result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule
